>>> rtl/core/mtfd_pkg.sv
// shared types and constants for the move-to-front event dedup block
package mtfd_pkg;

    localparam int HISTORY_DEPTH_DEF = 256;

    localparam int SRC_W  = 32;
    localparam int LINE_W = 20;
    localparam int MSG_W  = 32;
    localparam int HELD_W = 9;

    localparam int KEY_W     = SRC_W + LINE_W + MSG_W;
    localparam int IN_DATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_W     = 1 + HELD_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [MSG_W-1:0]  message_tag;
        logic [LINE_W-1:0] line_number;
        logic [SRC_W-1:0]  source_tag;
    } t_key;

    // per-cycle commands from the sequencer to every cell of the row
    typedef struct packed {
        logic cmp;
        logic shift;
    } t_cell_ctl;

endpackage

>>> rtl/core/mtfd_cell.sv
// one history cell: holds a key, compares it and takes its neighbor's key on a shift
module mtfd_cell
    import mtfd_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int OCC_W    = 9,
    parameter int IDX_W    = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [OCC_W-1:0] i_occ,
    input  logic [IDX_W-1:0] i_top,
    input  t_key             i_key,
    input  t_key             i_prev,
    output t_key             o_entry,
    output logic             o_match
);

    t_key r_entry;
    logic r_match;
    logic w_live;
    logic w_load;

    // only cells below the occupancy hold a real key
    assign w_live = OCC_W'(CELL_IDX) < i_occ;
    // cells from the head down to the top index move one place deeper
    assign w_load = IDX_W'(CELL_IDX) <= i_top;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && w_load) begin
            r_entry <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= w_live && (r_entry == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

>>> rtl/core/mtfd_match_enc.sv
// registered one-hot to index encoder for the match vector of the cell row
module mtfd_match_enc
    import mtfd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int IDX_W         = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [HISTORY_DEPTH-1:0] i_match,
    output logic                     o_any,
    output logic [IDX_W-1:0]         o_idx
);

    logic             r_any;
    logic [IDX_W-1:0] r_idx;
    logic             n_any;
    logic [IDX_W-1:0] n_idx;

    // held keys are unique, so at most one bit is set and an or of indexes works
    always_comb begin
        n_idx = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (i_match[k]) begin
                n_idx = n_idx | IDX_W'(k);
            end
        end
        n_any = |i_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_en) begin
            r_any <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
        end
    end

    assign o_any = r_any;
    assign o_idx = r_idx;

endmodule

>>> rtl/core/move_to_front_event_dedup_unit.sv
// top level of the move-to-front event dedup block
//
// Filters a stream of event keys through a most-recent-first history held in
// a row of cells. Input words come in on the s_axis channel (source tag, line
// number, message tag); one result word goes out on m_axis per input word
// (already_seen flag, entries held after the event). A held key moves to the
// head and is flagged as seen; a new key pushes every entry one cell deeper.
// The one-bit enable register is written through i_cfg_wen / i_cfg_wdata; the
// user must write it only while the block is idle, and the block has no guard
// for this. With it clear every event is reported and nothing moves. A word
// with history enabled passes cell compare, match encode, row shift and output
// load before o_m_axis_tvalid; with history disabled it goes straight to output
// load. No new word is taken until the current result is in the output register.
// A new word is taken while the previous result still waits in the output
// register; a stalled receiver holds the result, and the next result then
// waits in the sequencer until the output register frees up.
// Reset empties the history (occupancy zero) and sets the enable to 1.
module move_to_front_event_dedup_unit
    import mtfd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // source_tag [31:0], line_number [51:32], message_tag [83:52], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // already_seen [0], entries_held [9:1], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_wen,
    input  logic                  i_cfg_wdata
);

    localparam int OCC_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DEPTH_M1 = HISTORY_DEPTH - 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_ENC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_enable;
    t_key               r_key;
    logic [OCC_W-1:0]   r_occ;
    logic               r_seen;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_out_seen;
    logic [HELD_W-1:0]  r_out_held;

    logic               w_accept;
    logic               w_out_load;
    logic               w_any;
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_top;
    t_cell_ctl          w_ctl;
    t_key               w_entry [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] w_match;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    assign w_ctl.cmp   = (r_state == S_CMP);
    assign w_ctl.shift = (r_state == S_UPD);

    // deepest cell that moves: the match, else the first free cell or the last one
    always_comb begin
        if (w_any) begin
            w_top = w_idx;
        end else if (r_occ == OCC_W'(HISTORY_DEPTH)) begin
            w_top = IDX_W'(DEPTH_M1);
        end else begin
            w_top = r_occ[IDX_W-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
            t_key w_prev;
            if (g == 0) begin : g_head
                assign w_prev = r_key;
            end else begin : g_body
                assign w_prev = w_entry[g-1];
            end
            mtfd_cell #(
                .CELL_IDX (g),
                .OCC_W    (OCC_W),
                .IDX_W    (IDX_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_occ   (r_occ),
                .i_top   (w_top),
                .i_key   (r_key),
                .i_prev  (w_prev),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    mtfd_match_enc #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .IDX_W         (IDX_W)
    ) u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_state == S_ENC),
        .i_match (w_match),
        .o_any   (w_any),
        .o_idx   (w_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = r_enable ? S_CMP : S_OUT;
                end
            end
            S_CMP: begin
                n_state = S_ENC;
            end
            S_ENC: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                r_enable <= i_cfg_wdata;
            end
            if (w_ctl.shift && !w_any && (r_occ != OCC_W'(HISTORY_DEPTH))) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.source_tag  <= i_s_axis_tdata[SRC_W-1:0];
            r_key.line_number <= i_s_axis_tdata[SRC_W+LINE_W-1:SRC_W];
            r_key.message_tag <= i_s_axis_tdata[KEY_W-1:SRC_W+LINE_W];
            r_seen            <= 1'b0;
        end else if (w_ctl.shift) begin
            r_seen <= w_any;
        end
        if (w_out_load) begin
            r_out_seen <= r_seen;
            r_out_held <= HELD_W'(r_occ);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, r_out_held, r_out_seen};

endmodule

>>> rtl/core/mtfd_checker.sv
// port-level checker for the move-to-front event dedup block, bound to the top level
module mtfd_checker
    import mtfd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int HELD_MAX = (1 << HELD_W) - 1;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // one word at a time: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (HISTORY_DEPTH >= HELD_MAX) ||
            (o_m_axis_tdata[HELD_W:1] <= HELD_W'(HISTORY_DEPTH)))
        else $error("entries held above history depth");

    // a seen key implies a non-empty history
    a_seen_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> (HISTORY_DEPTH > HELD_MAX) ||
            (o_m_axis_tdata[HELD_W:1] != '0))
        else $error("seen event with empty history");

endmodule

bind move_to_front_event_dedup_unit mtfd_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_mtfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/move_to_front_event_dedup_unit_tb.sv
// self-checking testbench for the move-to-front event dedup unit, with a history scoreboard
module move_to_front_event_dedup_unit_tb;
    import mtfd_pkg::*;

    localparam int DEPTH          = HISTORY_DEPTH_DEF;
    localparam int KEY_POOL       = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              seen;
        logic [HELD_W-1:0] held;
    } t_verdict;

    // keeps its own copy of the history and queues the verdict for every accepted word
    class dedup_scoreboard;
        t_key        held_keys [DEPTH];
        int unsigned occupancy;
        bit          filter_on;
        t_verdict    pending_verdicts [$];
        int unsigned mismatches;
        int unsigned events_noted;
        int unsigned verdicts_checked;
        int unsigned repeats_seen;
        int unsigned evictions;
        int unsigned bypassed;
        int unsigned peak_held;

        function new();
            occupancy        = 0;
            filter_on        = 1'b1;
            mismatches       = 0;
            events_noted     = 0;
            verdicts_checked = 0;
            repeats_seen     = 0;
            evictions        = 0;
            bypassed         = 0;
            peak_held        = 0;
        endfunction

        function void note_event(t_key k);
            t_verdict    v;
            int unsigned top;
            bit          hit;
            hit = 1'b0;
            if (filter_on) begin
                top = (occupancy == DEPTH) ? DEPTH - 1 : occupancy;
                for (int i = 0; i < occupancy && !hit; i++) begin
                    if (held_keys[i] == k) begin
                        hit = 1'b1;
                        top = i;
                    end
                end
                if (!hit && occupancy == DEPTH) evictions++;
                // entries above the match (or the whole row) move one deeper
                for (int j = top; j > 0; j--) held_keys[j] = held_keys[j-1];
                held_keys[0] = k;
                if (!hit && occupancy < DEPTH) occupancy++;
            end else begin
                bypassed++;
            end
            if (hit) repeats_seen++;
            if (occupancy > peak_held) peak_held = occupancy;
            v.seen = hit;
            v.held = HELD_W'(occupancy);
            pending_verdicts.push_back(v);
            events_noted++;
        endfunction

        function void check_verdict(logic [OUT_DATA_W-1:0] word);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h with nothing pending", word);
                return;
            end
            v = pending_verdicts.pop_front();
            verdicts_checked++;
            if (word[0] !== v.seen || word[HELD_W:1] !== v.held) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: expected seen=%0b held=%0d, ",
                              "got seen=%0b held=%0d"},
                             verdicts_checked, v.seen, v.held, word[0], word[HELD_W:1]);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_wen = 1'b0;
    logic                  i_cfg_wdata = 1'b0;

    dedup_scoreboard dedup = new();
    t_key            key_pool [KEY_POOL];
    int unsigned     items_sent = 0;
    int unsigned     cfg_writes = 0;
    int unsigned     cycle_count = 0;
    int unsigned     stall_left = 0;
    int unsigned     idle_cycles = 0;

    move_to_front_event_dedup_unit #(
        .HISTORY_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rand_field(int w);
        logic [31:0] r;
        case ($urandom_range(0, 7))
            0:       r = '0;
            1:       r = '1;
            default: r = $urandom;
        endcase
        return r & 32'((64'd1 << w) - 1);
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.source_tag  = rand_field(SRC_W);
        k.line_number = LINE_W'(rand_field(LINE_W));
        k.message_tag = rand_field(MSG_W);
        return k;
    endfunction

    function automatic t_key make_key(logic [SRC_W-1:0] src, logic [LINE_W-1:0] line,
                                      logic [MSG_W-1:0] msg);
        t_key k;
        k.source_tag  = src;
        k.line_number = line;
        k.message_tag = msg;
        return k;
    endfunction

    // mix of recurring keys, held keys (deepest one favored), near misses and fresh keys
    function automatic t_key next_key();
        int unsigned roll;
        int unsigned n;
        int unsigned idx;
        int unsigned bitpos;
        t_key        k;
        roll = $urandom_range(0, 99);
        n    = dedup.occupancy;
        if (roll < 40) begin
            k = key_pool[$urandom_range(0, KEY_POOL - 1)];
        end else if (roll < 65 && n > 0) begin
            idx = ($urandom_range(0, 3) == 0) ? n - 1 : $urandom_range(0, n - 1);
            k   = dedup.held_keys[idx];
        end else if (roll < 80 && n > 0) begin
            k = dedup.held_keys[$urandom_range(0, n - 1)];
            case ($urandom_range(0, 2))
                0: begin
                    bitpos = $urandom_range(0, SRC_W - 1);
                    k.source_tag[bitpos] = ~k.source_tag[bitpos];
                end
                1: begin
                    bitpos = $urandom_range(0, LINE_W - 1);
                    k.line_number[bitpos] = ~k.line_number[bitpos];
                end
                default: begin
                    bitpos = $urandom_range(0, MSG_W - 1);
                    k.message_tag[bitpos] = ~k.message_tag[bitpos];
                end
            endcase
        end else begin
            k = random_key();
        end
        return k;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_event(t_key k);
        int unsigned gap;
        // every fourth run of 64 words goes back to back
        gap = (((items_sent / 64) % 4) == 3) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - KEY_W){1'b0}}, k};
        do @(posedge i_clk); while (!o_s_axis_tready);
        dedup.note_event(k);
        items_sent++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (dedup.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_filter(bit on);
        drain_results();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        dedup.filter_on = on;
        cfg_writes++;
    endtask

    task automatic run_random(int unsigned count);
        repeat (count) send_event(next_key());
    endtask

    task automatic run_directed();
        send_event(make_key('0, '0, '0));
        send_event(make_key('0, '0, '0));           // repeat at the head
        send_event(make_key('1, '1, '1));
        send_event(make_key('0, '0, '0));           // match one deep moves to front
        send_event(make_key(32'h1, '0, '0));        // one field differs at a time
        send_event(make_key('0, 20'h1, '0));
        send_event(make_key('0, '0, 32'h1));
        send_event(make_key(32'h8000_0000, 20'h8_0000, 32'h8000_0000));
        send_event(make_key('1, '1, '1));           // match deep in the row
        send_event(make_key('1, '0, '1));
        send_event(make_key('0, '1, '0));
        send_event(dedup.held_keys[dedup.occupancy - 1]);
        send_event(dedup.held_keys[0]);
        send_event(make_key(32'hA5A5_A5A5, 20'h5_A5A5, 32'h5A5A_5A5A));
        send_event(make_key(32'h5A5A_5A5A, 20'hA_5A5A, 32'hA5A5_A5A5));
        // filtering off: nothing moves, every event reported
        set_filter(1'b0);
        send_event(dedup.held_keys[0]);
        send_event(make_key(32'h1234_5678, 20'h9_ABCD, 32'hDEAD_BEEF));
        send_event(make_key('1, '1, '1));
        set_filter(1'b1);
        send_event(make_key(32'h1234_5678, 20'h9_ABCD, 32'hDEAD_BEEF));
        send_event(dedup.held_keys[dedup.occupancy - 1]);
    endtask

    // receiver stalls, with stall-free windows
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (((cycle_count >> 8) % 4) != 3 && $urandom_range(0, 7) == 0) begin
            stall_left      <= pick_stall() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            dedup.check_verdict(o_m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("** move_to_front_event_dedup_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_filter(1'b1);
        run_directed();
        run_random(800);        // fills the row and runs it full
        set_filter(1'b0);
        run_random(150);
        set_filter(1'b1);
        run_random(700);
        set_filter(1'b0);
        run_random(50);
        set_filter(1'b1);
        run_random(200);

        drain_results();
        repeat (20) @(posedge i_clk);

        $display({"covered %0d events: %0d repeats suppressed, %0d evictions from a full row, ",
                  "%0d with filtering off, peak occupancy %0d"},
                 dedup.events_noted, dedup.repeats_seen, dedup.evictions, dedup.bypassed,
                 dedup.peak_held);
        $display("%0d results checked over %0d enable writes, %0d mismatches",
                 dedup.verdicts_checked, cfg_writes, dedup.mismatches);
        if (dedup.mismatches == 0 && dedup.pending_verdicts.size() == 0) begin
            $display("** move_to_front_event_dedup_unit: PASSED **");
        end else begin
            $display("** move_to_front_event_dedup_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mtfd_pkg.sv
rtl/core/mtfd_cell.sv
rtl/core/mtfd_match_enc.sv
rtl/core/move_to_front_event_dedup_unit.sv
rtl/core/mtfd_checker.sv
tb/move_to_front_event_dedup_unit_tb.sv
